[rtl/wcc_pkg.sv]
// Shared types, constants and field layouts for the wall clock calendar.
// No dependencies; every other file of the block imports this package.

package wcc_pkg;

   // Tick bookkeeping: the tick count wraps at 2^32, kept as seconds plus ticks.
   localparam longint unsigned TICKS_PER_SECOND = 1000;
   localparam longint unsigned TICK_COUNT_MAX   = 64'hFFFF_FFFF;
   localparam longint unsigned SEC_LAST         = TICK_COUNT_MAX / TICKS_PER_SECOND;
   localparam longint unsigned TICK_WRAP        = TICK_COUNT_MAX % TICKS_PER_SECOND;
   localparam int TICK_W = $clog2(TICKS_PER_SECOND);
   localparam int SEC_W  = $clog2(SEC_LAST + 1);

   // Port widths
   localparam int EPOCH_W    = 32;
   localparam int TZ_W       = 17;
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 2;

   // Request data layout (lowest bit first)
   localparam int REQ_EPOCH_LSB    = 0;
   localparam int REQ_COMPLETE_LSB = 32;
   localparam int REQ_FIRST_LSB    = 33;
   localparam int REQ_STRATUM_LSB  = 41;

   // Response data layout (lowest bit first)
   localparam int RSP_HOUR_LSB  = 0;
   localparam int RSP_MIN_LSB   = 5;
   localparam int RSP_SEC_LSB   = 11;
   localparam int RSP_WDAY_LSB  = 17;
   localparam int RSP_DAY_LSB   = 20;
   localparam int RSP_MONTH_LSB = 25;
   localparam int RSP_YEAR_LSB  = 29;
   localparam int RSP_PAD_LSB   = 41;

   // Response user bits
   localparam int RSP_VALID_BIT  = 0;
   localparam int RSP_ACCEPT_BIT = 1;

   // Item kinds
   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_SET   = 2'd1,
      FUNC_REPLY = 2'd2
   } wcc_func_type;

   // SNTP reply checks
   localparam logic [31:0] NTP_UNIX_DELTA = 32'd2208988800;
   localparam logic [2:0]  MODE_SERVER    = 3'd4;
   localparam logic [2:0]  MODE_BROADCAST = 3'd5;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Back pipeline length, output register included
   localparam int BACK_STAGES = 9;

   typedef struct packed {
      logic              time_valid;
      logic              reply_accepted;
      logic [EPOCH_W-1:0] ref_epoch;
      logic [SEC_W-1:0]  elapsed_sec;
   } wcc_entry_type;

   typedef struct packed {
      logic time_valid;
      logic reply_accepted;
   } wcc_flags_type;

   // Seconds to days: epoch >> 7, then divide by 675 with an exact reciprocal
   localparam longint unsigned SECS_PER_DAY = 86400;
   localparam int              DAY_SHIFT    = 7;
   localparam longint unsigned DAY_DIV      = SECS_PER_DAY >> DAY_SHIFT;
   localparam int              DAY_K        = 35;
   localparam longint unsigned DAY_RECIP    = ((64'd1 << DAY_K) + DAY_DIV - 1) / DAY_DIV;

   // Time of day
   localparam longint unsigned SECS_PER_HOUR = 3600;
   localparam int              HOUR_K        = 29;
   localparam longint unsigned HOUR_RECIP    =
      ((64'd1 << HOUR_K) + SECS_PER_HOUR - 1) / SECS_PER_HOUR;
   localparam longint unsigned SECS_PER_MIN  = 60;
   localparam int              MIN_K         = 18;
   localparam longint unsigned MIN_RECIP     =
      ((64'd1 << MIN_K) + SECS_PER_MIN - 1) / SECS_PER_MIN;

   // Weekday
   localparam longint unsigned DAYS_PER_WEEK = 7;
   localparam int              WEEK_K        = 19;
   localparam longint unsigned WEEK_RECIP    =
      ((64'd1 << WEEK_K) + DAYS_PER_WEEK - 1) / DAYS_PER_WEEK;

   // Civil date: 400-year eras, years starting March 1
   localparam longint unsigned CIVIL_SHIFT   = 719468;
   localparam longint unsigned DAYS_PER_ERA  = 146097;
   localparam longint unsigned ERA_SPLIT     = 5 * DAYS_PER_ERA - CIVIL_SHIFT;
   localparam longint unsigned ERA_LO_OFFSET = CIVIL_SHIFT - 4 * DAYS_PER_ERA;
   localparam longint unsigned YEARS_PER_ERA = 400;
   localparam longint unsigned ERA_LO_YEAR   = 4 * YEARS_PER_ERA;
   localparam longint unsigned ERA_HI_YEAR   = 5 * YEARS_PER_ERA;
   localparam longint unsigned DAYS_PER_4Y   = 1460;
   localparam int              Q4_K          = 29;
   localparam longint unsigned Q4_RECIP      =
      ((64'd1 << Q4_K) + DAYS_PER_4Y - 1) / DAYS_PER_4Y;
   localparam longint unsigned DAYS_PER_CENT = 36524;
   localparam longint unsigned DAYS_ERA_LAST = 146096;
   localparam longint unsigned DAYS_PER_YEAR = 365;
   localparam int              YEAR_K        = 27;
   localparam longint unsigned YEAR_RECIP    =
      ((64'd1 << YEAR_K) + DAYS_PER_YEAR - 1) / DAYS_PER_YEAR;
   localparam longint unsigned MONTH_SPAN    = 153;
   localparam int              MP_K          = 19;
   localparam longint unsigned MP_RECIP      =
      ((64'd1 << MP_K) + MONTH_SPAN - 1) / MONTH_SPAN;
   localparam longint unsigned MP_MUL        = 5 * MP_RECIP;
   localparam longint unsigned MP_ADD        = 2 * MP_RECIP;
   localparam logic [3:0]      MP_JAN        = 4'd10;

   // Day of the March-based year on which each month starts
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] base;
      case (mp)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd61;
         4'd3:    base = 9'd92;
         4'd4:    base = 9'd122;
         4'd5:    base = 9'd153;
         4'd6:    base = 9'd184;
         4'd7:    base = 9'd214;
         4'd8:    base = 9'd245;
         4'd9:    base = 9'd275;
         4'd10:   base = 9'd306;
         4'd11:   base = 9'd337;
         default: base = 9'd0;
      endcase
      return base;
   endfunction

endpackage

[rtl/wcc_front.sv]
// Front part: accepts request items, checks SNTP replies and updates the clock state.
// Depends on wcc_pkg; pushes one state snapshot per item into wcc_queue.

module wcc_front
   import wcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  push_valid,
   input  logic                  push_ready,
   output wcc_entry_type         push_entry
);

   logic                clock_set_ff,    clock_set_in;
   logic [EPOCH_W-1:0]  ref_epoch_ff,    ref_epoch_in;
   logic [SEC_W-1:0]    elapsed_sec_ff,  elapsed_sec_in;
   logic [TICK_W-1:0]   elapsed_tick_ff, elapsed_tick_in;
   logic                accepted;
   logic                reply_ok;
   logic                take;
   logic [EPOCH_W-1:0]  epoch_value;
   logic                reply_complete;
   logic [7:0]          ntp_first_byte;
   logic [7:0]          ntp_stratum;
   logic [2:0]          mode;

   // Unpack the request
   assign epoch_value    = req_tdata[REQ_EPOCH_LSB +: EPOCH_W];
   assign reply_complete = req_tdata[REQ_COMPLETE_LSB];
   assign ntp_first_byte = req_tdata[REQ_FIRST_LSB +: 8];
   assign ntp_stratum    = req_tdata[REQ_STRATUM_LSB +: 8];
   assign mode           = ntp_first_byte[2:0];

   assign req_tready = push_ready;
   assign take       = req_tvalid && push_ready;

   // Check a reply: complete, server or broadcast mode, nonzero stratum, after 1970
   assign reply_ok = reply_complete && (mode == MODE_SERVER || mode == MODE_BROADCAST)
                     && (ntp_stratum != 8'd0) && (epoch_value > NTP_UNIX_DELTA);

   // Next clock state for this item
   always_comb begin
      clock_set_in    = clock_set_ff;
      ref_epoch_in    = ref_epoch_ff;
      elapsed_sec_in  = elapsed_sec_ff;
      elapsed_tick_in = elapsed_tick_ff;
      accepted        = 1'b0;
      case (req_tuser)
         FUNC_TICK: begin
            // advance the tick count, wrapping as a 32-bit count would
            if (elapsed_sec_ff == SEC_W'(SEC_LAST) &&
                elapsed_tick_ff == TICK_W'(TICK_WRAP)) begin
               elapsed_sec_in  = '0;
               elapsed_tick_in = '0;
            end else if (elapsed_tick_ff == TICK_W'(TICKS_PER_SECOND - 1)) begin
               elapsed_sec_in  = elapsed_sec_ff + SEC_W'(1);
               elapsed_tick_in = '0;
            end else begin
               elapsed_tick_in = elapsed_tick_ff + TICK_W'(1);
            end
         end
         FUNC_SET: begin
            clock_set_in    = 1'b1;
            ref_epoch_in    = epoch_value;
            elapsed_sec_in  = '0;
            elapsed_tick_in = '0;
         end
         FUNC_REPLY: begin
            if (reply_ok) begin
               clock_set_in    = 1'b1;
               ref_epoch_in    = epoch_value - NTP_UNIX_DELTA;
               elapsed_sec_in  = '0;
               elapsed_tick_in = '0;
               accepted        = 1'b1;
            end
         end
         default: begin
            // unused kind: report the clock only
         end
      endcase
   end

   // Commit the state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_set_ff    <= 1'b0;
         ref_epoch_ff    <= '0;
         elapsed_sec_ff  <= '0;
         elapsed_tick_ff <= '0;
      end else if (take) begin
         clock_set_ff    <= clock_set_in;
         ref_epoch_ff    <= ref_epoch_in;
         elapsed_sec_ff  <= elapsed_sec_in;
         elapsed_tick_ff <= elapsed_tick_in;
      end
   end

   // Hand the updated snapshot to the back part
   assign push_valid                = req_tvalid;
   assign push_entry.time_valid     = clock_set_in;
   assign push_entry.reply_accepted = accepted;
   assign push_entry.ref_epoch      = ref_epoch_in;
   assign push_entry.elapsed_sec    = elapsed_sec_in;

endmodule

[rtl/wcc_queue.sv]
// Short item queue between the front and back parts of the wall clock calendar.
// Depends on wcc_pkg for the entry type and depth.

module wcc_queue
   import wcc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  wcc_entry_type in_entry,
   output logic          out_valid,
   input  logic          out_ready,
   output wcc_entry_type out_entry
);

   wcc_entry_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff,  count_in;
   logic               push;
   logic               pop;

   assign in_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_entry = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

[rtl/wcc_back.sv]
// Back part: turns each clock snapshot into local time of day, weekday and civil date.
// Depends on wcc_pkg; holds the time zone register and the result register.

module wcc_back
   import wcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [TZ_W-1:0]       csr_wr_data,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  wcc_entry_type         pop_entry,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   logic [TZ_W-1:0]        tz_ff;
   logic [BACK_STAGES-1:0] vld_ff, vld_in;
   wcc_flags_type          flg_ff [BACK_STAGES];
   logic                   advance;

   // Stage registers and their next values
   logic [31:0] s1_e_ff, s1_e_in;

   logic [50:0] s2_prod;
   logic [15:0] s2_days_ff;
   logic [24:0] s2_x_ff;
   logic [6:0]  s2_elow_ff;

   logic [24:0] s3_rem;
   logic [32:0] s3_wprod;
   logic [16:0] s3_sod_ff, s3_sod_in;
   logic [17:0] s3_doe_ff, s3_doe_in;
   logic        s3_era5_ff, s3_era5_in;
   logic [15:0] s3_days_ff;
   logic [13:0] s3_q7_ff;

   logic [34:0] s4_hprod;
   logic [36:0] s4_aprod;
   logic [4:0]  s4_hour_ff;
   logic [16:0] s4_sod_ff;
   logic [17:0] s4_doe_ff;
   logic        s4_era5_ff;
   logic [6:0]  s4_a_ff;
   logic [2:0]  s4_b_ff, s4_b_in;
   logic        s4_c_ff;
   logic [2:0]  s4_wd_ff, s4_wd_in;

   logic [4:0]  s5_hour_ff;
   logic [11:0] s5_soh_ff, s5_soh_in;
   logic [17:0] s5_t_ff;
   logic [17:0] s5_doe_ff;
   logic        s5_era5_ff;
   logic [2:0]  s5_wd_ff;

   logic [24:0] s6_mprod;
   logic [36:0] s6_yprod;
   logic [4:0]  s6_hour_ff;
   logic [11:0] s6_soh_ff;
   logic [5:0]  s6_min_ff;
   logic [2:0]  s6_wd_ff;
   logic [8:0]  s6_yoe_ff;
   logic [17:0] s6_doe_ff;
   logic        s6_era5_ff;

   logic [11:0] s7_sec_wide;
   logic [1:0]  s7_yc;
   logic [17:0] s7_doy_wide;
   logic [4:0]  s7_hour_ff;
   logic [5:0]  s7_min_ff;
   logic [5:0]  s7_sec_ff;
   logic [2:0]  s7_wd_ff;
   logic [8:0]  s7_yoe_ff;
   logic [8:0]  s7_doy_ff;
   logic        s7_era5_ff;

   logic [22:0] s8_mpprod;
   logic [4:0]  s8_hour_ff;
   logic [5:0]  s8_min_ff;
   logic [5:0]  s8_sec_ff;
   logic [2:0]  s8_wd_ff;
   logic [8:0]  s8_yoe_ff;
   logic [8:0]  s8_doy_ff;
   logic        s8_era5_ff;
   logic [3:0]  s8_mp_ff;

   logic [8:0]            s9_day_wide;
   logic [3:0]            s9_month;
   logic [11:0]           s9_year;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // Move the whole pipeline unless the result register is held
   assign advance   = !vld_ff[BACK_STAGES-1] || rsp_tready;
   assign pop_ready = advance;
   assign vld_in    = {vld_ff[BACK_STAGES-2:0], pop_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         tz_ff  <= '0;
      end else begin
         if (advance) begin
            vld_ff <= vld_in;
         end
         if (csr_wr_en) begin
            tz_ff <= csr_wr_data;
         end
      end
   end

   // Carry the flags along with the data
   always_ff @(posedge clock) begin
      if (advance) begin
         flg_ff[0] <= '{time_valid: pop_entry.time_valid,
                        reply_accepted: pop_entry.reply_accepted};
         for (int i = 1; i < BACK_STAGES; i++) begin
            flg_ff[i] <= flg_ff[i-1];
         end
      end
   end

   // Stage 1: local epoch, zero while the clock is unset
   assign s1_e_in = pop_entry.time_valid
                    ? pop_entry.ref_epoch + 32'(pop_entry.elapsed_sec)
                      + {{(32-TZ_W){tz_ff[TZ_W-1]}}, tz_ff}
                    : '0;

   // Stage 2: day number by reciprocal of 675 on the epoch over 128
   assign s2_prod = 51'(s1_e_ff[31:DAY_SHIFT]) * 51'(DAY_RECIP);

   // Stage 3: second of day, era split, weekday quotient
   assign s3_rem     = s2_x_ff - 25'(25'(s2_days_ff) * 25'(DAY_DIV));
   assign s3_sod_in  = {s3_rem[9:0], s2_elow_ff};
   assign s3_era5_in = (s2_days_ff >= 16'(ERA_SPLIT));
   assign s3_doe_in  = s3_era5_in ? 18'(s2_days_ff) - 18'(ERA_SPLIT)
                                  : 18'(s2_days_ff) + 18'(ERA_LO_OFFSET);
   assign s3_wprod   = 33'(s2_days_ff) * 33'(WEEK_RECIP);

   // Stage 4: hour, four-year count, century count, weekday
   assign s4_hprod = 35'(s3_sod_ff) * 35'(HOUR_RECIP);
   assign s4_aprod = 37'(s3_doe_ff) * 37'(Q4_RECIP);
   assign s4_wd_in = 3'(s3_days_ff - 16'(s3_q7_ff) * 16'(DAYS_PER_WEEK));
   assign s4_b_in  = 3'(s3_doe_ff >= 18'(DAYS_PER_CENT))
                   + 3'(s3_doe_ff >= 18'(2 * DAYS_PER_CENT))
                   + 3'(s3_doe_ff >= 18'(3 * DAYS_PER_CENT))
                   + 3'(s3_doe_ff >= 18'(4 * DAYS_PER_CENT));

   // Stage 5: second of hour, leap-corrected day of era
   assign s5_soh_in = 12'(s4_sod_ff - 17'(s4_hour_ff) * 17'(SECS_PER_HOUR));

   // Stage 6: minute and year of era
   assign s6_mprod = 25'(s5_soh_ff) * 25'(MIN_RECIP);
   assign s6_yprod = 37'(s5_t_ff) * 37'(YEAR_RECIP);

   // Stage 7: second and day of year
   assign s7_sec_wide = s6_soh_ff - 12'(s6_min_ff) * 12'(SECS_PER_MIN);
   assign s7_yc       = (s6_yoe_ff >= 9'd300) ? 2'd3 :
                        (s6_yoe_ff >= 9'd200) ? 2'd2 :
                        (s6_yoe_ff >= 9'd100) ? 2'd1 : 2'd0;
   assign s7_doy_wide = s6_doe_ff - (18'(s6_yoe_ff) * 18'(DAYS_PER_YEAR)
                        + 18'(s6_yoe_ff[8:2]) - 18'(s7_yc));

   // Stage 8: March-based month index
   assign s8_mpprod = 23'(s7_doy_ff) * 23'(MP_MUL) + 23'(MP_ADD);

   // Stage 9: day, month, year and packing
   assign s9_day_wide = s8_doy_ff - month_start(s8_mp_ff) + 9'd1;
   assign s9_month    = (s8_mp_ff < MP_JAN) ? s8_mp_ff + 4'd3 : s8_mp_ff - 4'd9;
   assign s9_year     = 12'(s8_yoe_ff)
                        + (s8_era5_ff ? 12'(ERA_HI_YEAR) : 12'(ERA_LO_YEAR))
                        + 12'(s9_month <= 4'd2);

   always_comb begin
      rsp_tdata_in = '0;
      rsp_tdata_in[RSP_HOUR_LSB  +: 5]  = s8_hour_ff;
      rsp_tdata_in[RSP_MIN_LSB   +: 6]  = s8_min_ff;
      rsp_tdata_in[RSP_SEC_LSB   +: 6]  = s8_sec_ff;
      rsp_tdata_in[RSP_WDAY_LSB  +: 3]  = s8_wd_ff;
      rsp_tdata_in[RSP_DAY_LSB   +: 5]  = s9_day_wide[4:0];
      rsp_tdata_in[RSP_MONTH_LSB +: 4]  = s9_month;
      rsp_tdata_in[RSP_YEAR_LSB  +: 12] = s9_year;
   end

   // Payload registers: advance with the pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_e_ff    <= s1_e_in;

         s2_days_ff <= s2_prod[DAY_K +: 16];
         s2_x_ff    <= s1_e_ff[31:DAY_SHIFT];
         s2_elow_ff <= s1_e_ff[DAY_SHIFT-1:0];

         s3_sod_ff  <= s3_sod_in;
         s3_doe_ff  <= s3_doe_in;
         s3_era5_ff <= s3_era5_in;
         s3_days_ff <= s2_days_ff;
         s3_q7_ff   <= s3_wprod[WEEK_K +: 14];

         s4_hour_ff <= s4_hprod[HOUR_K +: 5];
         s4_sod_ff  <= s3_sod_ff;
         s4_doe_ff  <= s3_doe_ff;
         s4_era5_ff <= s3_era5_ff;
         s4_a_ff    <= s4_aprod[Q4_K +: 7];
         s4_b_ff    <= s4_b_in;
         s4_c_ff    <= (s3_doe_ff == 18'(DAYS_ERA_LAST));
         s4_wd_ff   <= s4_wd_in;

         s5_hour_ff <= s4_hour_ff;
         s5_soh_ff  <= s5_soh_in;
         s5_t_ff    <= s4_doe_ff - 18'(s4_a_ff) + 18'(s4_b_ff) - 18'(s4_c_ff);
         s5_doe_ff  <= s4_doe_ff;
         s5_era5_ff <= s4_era5_ff;
         s5_wd_ff   <= s4_wd_ff;

         s6_hour_ff <= s5_hour_ff;
         s6_soh_ff  <= s5_soh_ff;
         s6_min_ff  <= s6_mprod[MIN_K +: 6];
         s6_wd_ff   <= s5_wd_ff;
         s6_yoe_ff  <= s6_yprod[YEAR_K +: 9];
         s6_doe_ff  <= s5_doe_ff;
         s6_era5_ff <= s5_era5_ff;

         s7_hour_ff <= s6_hour_ff;
         s7_min_ff  <= s6_min_ff;
         s7_sec_ff  <= s7_sec_wide[5:0];
         s7_wd_ff   <= s6_wd_ff;
         s7_yoe_ff  <= s6_yoe_ff;
         s7_doy_ff  <= s7_doy_wide[8:0];
         s7_era5_ff <= s6_era5_ff;

         s8_hour_ff <= s7_hour_ff;
         s8_min_ff  <= s7_min_ff;
         s8_sec_ff  <= s7_sec_ff;
         s8_wd_ff   <= s7_wd_ff;
         s8_yoe_ff  <= s7_yoe_ff;
         s8_doy_ff  <= s7_doy_ff;
         s8_era5_ff <= s7_era5_ff;
         s8_mp_ff   <= s8_mpprod[MP_K +: 4];

         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid                = vld_ff[BACK_STAGES-1];
   assign rsp_tdata                 = rsp_tdata_ff;
   assign rsp_tuser[RSP_VALID_BIT]  = flg_ff[BACK_STAGES-1].time_valid;
   assign rsp_tuser[RSP_ACCEPT_BIT] = flg_ff[BACK_STAGES-1].reply_accepted;

endmodule

[rtl/wall_clock_calendar.sv]
// Top level of the wall clock calendar: front, queue and back part joined.
// Depends on wcc_pkg, wcc_front, wcc_queue and wcc_back.
//
//   port group   direction   payload
//   req_*        in          tuser: func; tdata: epoch, complete, first byte, stratum
//   rsp_*        out         tuser: time_valid, reply_accepted; tdata: time and date
//   csr_*        in          tz_offset_seconds, 17-bit signed
//
// One item per cycle sustained while results are taken; an item passes through the
// four-entry queue and then the registered stages of the back pipeline of constant
// reciprocal multiplies. Reset clears the clock state, the time zone and all valid
// flags at once. A held result freezes the back pipeline; the queue keeps taking
// items until it fills, then req_tready drops.

module wall_clock_calendar
   import wcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // epoch_value[31:0], reply_complete[32], ntp_first_byte[40:33], ntp_stratum[48:41]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func[1:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hour[4:0], minute[10:5], second[16:11], weekday[19:17], day_of_month[24:20],
   // month[28:25], year[40:29]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // time_valid[0], reply_accepted[1]
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [TZ_W-1:0]       csr_wr_data
);

   logic          push_valid;
   logic          push_ready;
   wcc_entry_type push_entry;
   logic          pop_valid;
   logic          pop_ready;
   wcc_entry_type pop_entry;

   wcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   wcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   wcc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_entry   (pop_entry),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

[rtl/wcc_checker.sv]
// Port-level checks for the wall clock calendar, bound onto the top level.
// Depends on wcc_pkg for the response field layout.

module wcc_checker
   import wcc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;
   logic [2:0]  weekday;
   logic [4:0]  day;
   logic [3:0]  month;
   logic [11:0] year;

   assign hour    = rsp_tdata[RSP_HOUR_LSB  +: 5];
   assign minute  = rsp_tdata[RSP_MIN_LSB   +: 6];
   assign second  = rsp_tdata[RSP_SEC_LSB   +: 6];
   assign weekday = rsp_tdata[RSP_WDAY_LSB  +: 3];
   assign day     = rsp_tdata[RSP_DAY_LSB   +: 5];
   assign month   = rsp_tdata[RSP_MONTH_LSB +: 4];
   assign year    = rsp_tdata[RSP_YEAR_LSB  +: 12];

   // Reset empties the result side
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("held result changed");

   // An unset clock reports midnight, Thursday 1 January 1970
   a_unset_epoch0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[RSP_VALID_BIT] |->
         hour == 5'd0 && minute == 6'd0 && second == 6'd0 && weekday == 3'd0 &&
         day == 5'd1 && month == 4'd1 && year == 12'd1970)
      else $error("unset clock reports a date other than epoch zero");

   // An accepted reply always leaves the clock set
   a_accept_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[RSP_ACCEPT_BIT] |-> rsp_tuser[RSP_VALID_BIT])
      else $error("accepted reply without a valid clock");

   // Every field of a result stays inside its calendar range
   a_field_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> hour < 5'd24 && minute < 6'd60 && second < 6'd60 &&
         weekday < 3'd7 && day != 5'd0 && month != 4'd0 && month < 4'd13 &&
         year >= 12'd1970 && year <= 12'd2106)
      else $error("result field out of range");

endmodule

bind wall_clock_calendar wcc_checker u_wcc_checker (.*);
